// File: src/sspc_pkg.sv
// shared types and constants for the servo status packet checker
package sspc_pkg;

   localparam int BUFFER_BYTES  = 32;
   localparam int IDX_W         = $clog2(BUFFER_BYTES);
   localparam int CNT_W         = $clog2(BUFFER_BYTES + 1);
   localparam int PC_W          = 5;
   localparam int HDR_BYTE      = 8'hFF;
   localparam int MIN_FRAME     = 6;
   localparam int LEN_EXTRA     = 4;
   localparam int LEN_BIAS      = 2;
   localparam int SUM_START     = 2;
   localparam int HDR0_IDX      = 0;
   localparam int HDR1_IDX      = 1;
   localparam int ID_IDX        = 2;
   localparam int LEN_IDX       = 3;
   localparam int ERR_IDX       = 4;
   localparam int PAYLOAD_START = 5;
   localparam int ID_RESET      = 1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_HEADER   = 3'd2,
      ST_ID       = 3'd3,
      ST_LENGTH   = 3'd4,
      ST_CHECKSUM = 3'd5
   } status_type;

   typedef enum logic {
      DR_IDLE,
      DR_RUN
   } drain_state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       servo_error;
      logic [7:0]       payload_byte;
      logic             payload_valid;
      logic [PC_W-1:0]  payload_count;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic             fire;
      status_type       status;
      logic [7:0]       servo_error;
      logic [PC_W-1:0]  payload_count;
   } verdict_type;

   typedef struct packed {
      logic busy;
      logic slot_full;
   } drain_status_type;

endpackage

// File: src/sspc_frame_ram.sv
// frame byte store, one write port and one registered read port
module sspc_frame_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sspc_capture.sv
// byte intake, header capture, running sum and frame-end checks
module sspc_capture import sspc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  req_type          req_data,
   input  logic [7:0]       expected_id,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic [7:0]       wr_data,
   output verdict_type      verdict
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       hdr0_ff, hdr1_ff, id_ff, len_ff, err_ff, tail_ff;

   logic             store;
   logic [7:0]       b;
   logic [7:0]       hdr0_eff, hdr1_eff, id_eff, len_eff, err_eff, tail_eff, sum_eff;
   logic [CNT_W-1:0] n_eff;
   logic [7:0]       cs;
   logic [7:0]       cnt_full;
   status_type       status;

   assign b     = req_data.rx_byte;
   assign store = count_ff < CNT_W'(BUFFER_BYTES);

   always_comb begin
      hdr0_eff = (store && count_ff == CNT_W'(HDR0_IDX)) ? b : hdr0_ff;
      hdr1_eff = (store && count_ff == CNT_W'(HDR1_IDX)) ? b : hdr1_ff;
      id_eff   = (store && count_ff == CNT_W'(ID_IDX))   ? b : id_ff;
      len_eff  = (store && count_ff == CNT_W'(LEN_IDX))  ? b : len_ff;
      err_eff  = (store && count_ff == CNT_W'(ERR_IDX))  ? b : err_ff;
      tail_eff = store ? b : tail_ff;
      n_eff    = store ? CNT_W'(count_ff + 1'b1) : count_ff;
      sum_eff  = (store && count_ff >= CNT_W'(SUM_START)) ? 8'(sum_ff + b) : sum_ff;
      cs       = ~8'(sum_eff - tail_eff);
      cnt_full = 8'(len_eff - 8'(LEN_BIAS));
   end

   always_comb begin
      if (n_eff < CNT_W'(MIN_FRAME)) begin
         status = ST_SHORT;
      end else if (hdr0_eff != 8'(HDR_BYTE) || hdr1_eff != 8'(HDR_BYTE)) begin
         status = ST_HEADER;
      end else if (id_eff != expected_id) begin
         status = ST_ID;
      end else if (9'(n_eff) != 9'({1'b0, len_eff} + 9'(LEN_EXTRA))) begin
         status = ST_LENGTH;
      end else if (tail_eff != cs) begin
         status = ST_CHECKSUM;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      verdict.fire          = accept && req_data.frame_end;
      verdict.status        = status;
      verdict.servo_error   = (status == ST_OK || status == ST_CHECKSUM) ? err_eff : 8'd0;
      verdict.payload_count = (status == ST_OK) ? cnt_full[PC_W-1:0] : '0;
   end

   assign wr_en   = accept && store;
   assign wr_addr = count_ff[IDX_W-1:0];
   assign wr_data = b;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = n_eff;
            sum_in   = sum_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr0_ff <= hdr0_eff;
         hdr1_ff <= hdr1_eff;
         id_ff   <= id_eff;
         len_ff  <= len_eff;
         err_ff  <= err_eff;
         tail_ff <= tail_eff;
      end
   end

endmodule

// File: src/sspc_drain.sv
// result register and payload read-out sequencer
module sspc_drain import sspc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  verdict_type      verdict,
   input  logic [7:0]       rd_data,
   output logic             rd_en,
   output logic [IDX_W-1:0] rd_addr,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   output drain_status_type drain_status
);

   drain_state_type  state_ff, state_in;
   logic             out_valid_ff;
   rsp_type          out_data_ff;
   logic             pend_ff, pend_last_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [PC_W-1:0]  left_ff, cnt_ff;
   logic [7:0]       err_ff;

   logic             taken, slot_free, start_run, issue;

   assign taken     = out_valid_ff && !rsp_stall;
   assign slot_free = !out_valid_ff || taken;
   assign start_run = verdict.fire && verdict.status == ST_OK && verdict.payload_count != '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DR_IDLE: begin
            if (start_run) begin
               state_in = DR_RUN;
            end
         end
         DR_RUN: begin
            if (left_ff == '0 && !pend_ff) begin
               state_in = DR_IDLE;
            end
         end
         default: state_in = DR_IDLE;
      endcase
   end

   always_comb begin
      issue                  = 1'b0;
      drain_status.busy      = 1'b0;
      drain_status.slot_full = out_valid_ff;
      unique case (state_ff)
         DR_IDLE: begin
            issue             = 1'b0;
            drain_status.busy = 1'b0;
         end
         DR_RUN: begin
            issue             = !pend_ff && left_ff != '0 && slot_free;
            drain_status.busy = 1'b1;
         end
         default: begin
            issue             = 1'b0;
            drain_status.busy = 1'b0;
         end
      endcase
   end

   assign rd_en   = issue;
   assign rd_addr = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DR_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= issue;
         if (verdict.fire && !start_run) begin
            out_valid_ff <= 1'b1;
         end else if (pend_ff) begin
            out_valid_ff <= 1'b1;
         end else if (taken) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_run) begin
         addr_ff <= IDX_W'(PAYLOAD_START);
         left_ff <= verdict.payload_count;
         cnt_ff  <= verdict.payload_count;
         err_ff  <= verdict.servo_error;
      end else if (issue) begin
         addr_ff <= IDX_W'(addr_ff + 1'b1);
         left_ff <= PC_W'(left_ff - 1'b1);
      end
      if (issue) begin
         pend_last_ff <= left_ff == PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.fire && !start_run) begin
         out_data_ff.status        <= verdict.status;
         out_data_ff.servo_error   <= verdict.servo_error;
         out_data_ff.payload_byte  <= 8'd0;
         out_data_ff.payload_valid <= 1'b0;
         out_data_ff.payload_count <= '0;
         out_data_ff.last          <= 1'b1;
      end else if (pend_ff) begin
         out_data_ff.status        <= ST_OK;
         out_data_ff.servo_error   <= err_ff;
         out_data_ff.payload_byte  <= rd_data;
         out_data_ff.payload_valid <= 1'b1;
         out_data_ff.payload_count <= cnt_ff;
         out_data_ff.last          <= pend_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: src/servo_status_packet_checker.sv
// servo status packet checker top level
//
//   channel  direction  handshake          beat
//   req_     in         req_valid/stall    one received byte, frame_end on the last
//   rsp_     out        rsp_valid/stall    one result: status or one payload byte
//   csr_     in         csr_we             expected servo id
//
// a mid-frame byte is taken every cycle outside a payload run, also while a result waits
// in the output register; a frame-end beat is held off while that register is full;
// a failed or empty frame gives its result in the cycle after the frame-end beat
// a payload run reads the frame store once per byte, no new read while one is pending
// or the output register is held full, and req_stall stays high for the whole run
// reset clears the byte count, running sum and output register and sets the id to 1;
// the frame store needs no clearing pass
module servo_status_packet_checker import sspc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic [7:0] csr_wdata
);

   logic [7:0]       expected_id_ff;
   logic             accept;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;
   verdict_type      verdict;
   drain_status_type drain_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 8'(ID_RESET);
      end else if (csr_we) begin
         expected_id_ff <= csr_wdata;
      end
   end

   assign req_stall = drain_status.busy ||
                      (req_valid && req_data.frame_end && drain_status.slot_full);
   assign accept    = req_valid && !req_stall;

   sspc_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .expected_id (expected_id_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .verdict     (verdict)
   );

   sspc_frame_ram #(
      .DEPTH (BUFFER_BYTES),
      .WIDTH (8)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sspc_drain u_drain (
      .clock        (clock),
      .reset        (reset),
      .verdict      (verdict),
      .rd_data      (rd_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .drain_status (drain_status)
   );

endmodule

// File: src/sspc_checker.sv
// port-level checks for the servo status packet checker
module sspc_checker import sspc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // a frame end cannot be taken while a result is still waiting
   a_end_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && req_valid && req_data.frame_end |-> req_stall)
      else $error("frame end accepted over a waiting result");

   // input is held off in the middle of a payload run
   a_run_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.payload_valid && !rsp_data.last |=> req_stall)
      else $error("input taken during a payload run");

   // a mid-frame beat never produces a result
   a_mid_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.frame_end && !rsp_valid |=> !rsp_valid)
      else $error("result after a mid-frame beat");

endmodule

bind servo_status_packet_checker sspc_checker u_checker (.*);

// File: tb/sv/sspc_result_checker.sv
// predictor and scoreboard for the servo status packet checker channels
module sspc_result_checker import sspc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output int         mismatch_count,
   output int         results_pending
);

   logic [7:0] cfg_id;
   logic [7:0] frame_bytes [BUFFER_BYTES];
   int         bytes_held;
   logic [7:0] sum_from_id;
   rsp_type    frame_results [$];

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (frame_results.size() == 0) begin
         $error("result beat with nothing expected: status %0d payload_byte %0d",
                got.status, got.payload_byte);
         mismatch_count++;
      end else begin
         want = frame_results.pop_front();
         check_field("status", want.status, got.status);
         check_field("servo_error", want.servo_error, got.servo_error);
         check_field("payload_byte", want.payload_byte, got.payload_byte);
         check_field("payload_valid", want.payload_valid, got.payload_valid);
         check_field("payload_count", want.payload_count, got.payload_count);
         check_field("last", want.last, got.last);
      end
   endtask

   task automatic take_beat(input req_type beat);
      int         n;
      int         count;
      int         i;
      logic [7:0] expect_sum;
      status_type verdict;
      rsp_type    r;
      if (bytes_held < BUFFER_BYTES) begin
         frame_bytes[bytes_held] = beat.rx_byte;
         if (bytes_held >= SUM_START) begin
            sum_from_id = sum_from_id + beat.rx_byte;
         end
         bytes_held++;
      end
      if (beat.frame_end) begin
         n = bytes_held;
         bytes_held = 0;
         expect_sum = '0;
         if (n >= MIN_FRAME) begin
            // checksum byte itself is in the running sum, take it back out
            expect_sum = sum_from_id - frame_bytes[n - 1];
            expect_sum = ~expect_sum;
         end
         sum_from_id = '0;
         if (n < MIN_FRAME) begin
            verdict = ST_SHORT;
         end else if (frame_bytes[HDR0_IDX] != HDR_BYTE || frame_bytes[HDR1_IDX] != HDR_BYTE) begin
            verdict = ST_HEADER;
         end else if (frame_bytes[ID_IDX] != cfg_id) begin
            verdict = ST_ID;
         end else if (n != frame_bytes[LEN_IDX] + LEN_EXTRA) begin
            verdict = ST_LENGTH;
         end else if (frame_bytes[n - 1] != expect_sum) begin
            verdict = ST_CHECKSUM;
         end else begin
            verdict = ST_OK;
         end
         r = '0;
         r.status = verdict;
         r.last = 1'b1;
         if (verdict == ST_CHECKSUM) begin
            r.servo_error = frame_bytes[ERR_IDX];
         end
         if (verdict != ST_OK) begin
            frame_results.push_back(r);
         end else begin
            r.servo_error = frame_bytes[ERR_IDX];
            count = frame_bytes[LEN_IDX] - LEN_BIAS;
            if (count == 0) begin
               frame_results.push_back(r);
            end else begin
               for (i = 0; i < count; i++) begin
                  r.payload_byte = frame_bytes[PAYLOAD_START + i];
                  r.payload_valid = 1'b1;
                  r.payload_count = PC_W'(count);
                  r.last = (i == count - 1);
                  frame_results.push_back(r);
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_id = 8'(ID_RESET);
         bytes_held = 0;
         sum_from_id = '0;
         mismatch_count = 0;
         frame_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_result(rsp_data);
         end
         if (csr_we) begin
            cfg_id = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            take_beat(req_data);
         end
      end
      results_pending = frame_results.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// testbench top: clock, reset, frame stimulus, result stalls and final verdict
module tb_top import sspc_pkg::*; ();

   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 12;
   localparam int MAX_GAP          = 18;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 16;
   localparam int TIMEOUT_CYCLES   = 200000;
   localparam int RANDOM_BEATS     = 110;
   localparam int NUM_PHASES       = 4;

   localparam int FR_GOOD     = 0;
   localparam int FR_CHECKSUM = 1;
   localparam int FR_ID       = 2;
   localparam int FR_HEADER   = 3;
   localparam int FR_LENGTH   = 4;
   localparam int FR_SHORT    = 5;
   localparam int FR_NOISE    = 6;
   localparam int FR_FULL     = 7;
   localparam int FR_OVERFLOW = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = '0;

   int         mismatch_count;
   int         results_pending;
   bit         hold_off_request = 1'b0;
   int         send_quiet = 0;
   int         recv_quiet = 0;
   int         beats_sent = 0;
   logic [7:0] frame_buf [$];

   always #HALF_PERIOD clock = ~clock;

   servo_status_packet_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   sspc_result_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // idle cycles before a beat, with runs of back-to-back beats now and then
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(8, 30);
         return 0;
      end
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_beat(input logic [7:0] b, input bit is_end);
      int      gap;
      req_type beat;
      gap = draw_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      beat.rx_byte = b;
      beat.frame_end = is_end;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_buf.size(); i++) begin
         send_beat(frame_buf[i], i == frame_buf.size() - 1);
      end
      beats_sent += frame_buf.size();
   endtask

   task automatic fix_checksum();
      logic [7:0] sum;
      int         i;
      sum = '0;
      for (i = SUM_START; i < frame_buf.size() - 1; i++) begin
         sum = sum + frame_buf[i];
      end
      frame_buf[frame_buf.size() - 1] = ~sum;
   endtask

   task automatic build_good(input logic [7:0] id, input int data_len);
      int i;
      frame_buf.delete();
      frame_buf.push_back(8'(HDR_BYTE));
      frame_buf.push_back(8'(HDR_BYTE));
      frame_buf.push_back(id);
      frame_buf.push_back(8'(data_len + LEN_BIAS));
      frame_buf.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < data_len; i++) begin
         frame_buf.push_back(8'($urandom_range(0, 255)));
      end
      frame_buf.push_back(8'h00);
      fix_checksum();
   endtask

   function automatic int pick_kind();
      int d;
      d = $urandom_range(0, 99);
      if (d < 50) return FR_GOOD;
      if (d < 58) return FR_CHECKSUM;
      if (d < 65) return FR_ID;
      if (d < 72) return FR_HEADER;
      if (d < 79) return FR_LENGTH;
      if (d < 86) return FR_SHORT;
      if (d < 95) return FR_NOISE;
      if (d < 97) return FR_FULL;
      return FR_OVERFLOW;
   endfunction

   task automatic send_random_frame(input logic [7:0] id, input int kind);
      int data_len;
      int keep;
      int i;
      data_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, BUFFER_BYTES - MIN_FRAME)
                                              : $urandom_range(0, 6);
      if (kind == FR_FULL || kind == FR_OVERFLOW) begin
         data_len = BUFFER_BYTES - MIN_FRAME;
      end
      build_good(id, data_len);
      case (kind)
         FR_CHECKSUM: begin
            frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
         end
         FR_ID: begin
            frame_buf[ID_IDX] = id ^ 8'($urandom_range(1, 255));
            fix_checksum();
         end
         FR_HEADER: begin
            if ($urandom_range(0, 1) == 0) begin
               frame_buf[HDR0_IDX] ^= 8'($urandom_range(1, 255));
            end else begin
               frame_buf[HDR1_IDX] ^= 8'($urandom_range(1, 255));
            end
         end
         FR_LENGTH: begin
            if ($urandom_range(0, 1) == 0) begin
               frame_buf[LEN_IDX] ^= 8'($urandom_range(1, 255));
            end else begin
               frame_buf.push_back(8'($urandom_range(0, 255)));
            end
         end
         FR_SHORT: begin
            keep = $urandom_range(1, MIN_FRAME - 1);
            while (frame_buf.size() > keep) void'(frame_buf.pop_back());
         end
         FR_NOISE: begin
            keep = $urandom_range(1, 12);
            if ($urandom_range(0, 1) == 0) begin
               frame_buf.delete();
            end
            while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            while (frame_buf.size() < keep) frame_buf.push_back(8'($urandom_range(0, 255)));
         end
         FR_OVERFLOW: begin
            // trailing bytes past the buffer are dropped, frame_end beat included
            keep = $urandom_range(1, 6);
            for (i = 0; i < keep; i++) begin
               frame_buf.push_back(8'($urandom_range(0, 255)));
            end
         end
         default: begin
         end
      endcase
      send_frame();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_servo_id(input logic [7:0] id);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= id;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // result side stalls
   initial begin
      int hold;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         hold = draw_gap(recv_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && !hold_off_request);
         @(negedge clock);
      end
   end

   initial begin
      logic [7:0] phase_id;
      int         phase;
      int         frame_no;
      int         random_start;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone frame-end beat, too short
      send_beat(8'h00, 1'b1);
      beats_sent++;
      // result side holds off while the next frames arrive
      hold_off_request = 1'b1;
      while (hold_off_request) @(negedge clock);
      // empty payload at the reset id
      build_good(8'(ID_RESET), 0);
      send_frame();
      // payload extremes
      build_good(8'(ID_RESET), 2);
      frame_buf[ERR_IDX] = 8'h00;
      frame_buf[PAYLOAD_START] = 8'hFF;
      frame_buf[PAYLOAD_START + 1] = 8'h00;
      fix_checksum();
      send_frame();
      // checksum mismatch carries the servo error byte
      build_good(8'(ID_RESET), 0);
      frame_buf[ERR_IDX] = 8'hFF;
      fix_checksum();
      frame_buf[frame_buf.size() - 1] ^= 8'h01;
      send_frame();

      random_start = beats_sent;
      frame_no = 0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: phase_id = 8'h00;
            1: phase_id = 8'hFF;
            default: phase_id = 8'($urandom_range(0, 255));
         endcase
         set_servo_id(phase_id);
         while (beats_sent - random_start < (phase + 1) * RANDOM_BEATS / NUM_PHASES) begin
            send_random_frame(phase_id, (frame_no <= FR_OVERFLOW) ? frame_no : pick_kind());
            frame_no++;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
src/sspc_pkg.sv
src/sspc_frame_ram.sv
src/sspc_capture.sv
src/sspc_drain.sv
src/servo_status_packet_checker.sv
src/sspc_checker.sv
tb/sv/sspc_result_checker.sv
tb/sv/tb_top.sv
